[hdl/brace_record_field_parser_assert.svh]
// Assertion macros for the brace record field parser.
`ifndef BRACE_RECORD_FIELD_PARSER_ASSERT_SVH
`define BRACE_RECORD_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BRFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/brfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package brfp_pkg;

  localparam int NAME_BYTES  = 8;
  localparam int VALUE_BYTES = 12;
  localparam int NAME_CAP    = NAME_BYTES - 1;
  localparam int VALUE_CAP   = VALUE_BYTES - 1;

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int NLEN_W      = 3;
  localparam int VLEN_W      = 4;
  localparam int NTXT_W      = 56;
  localparam int VTXT_LO_W   = 64;
  localparam int VTXT_HI_W   = 24;
  localparam int VTXT_W      = VTXT_LO_W + VTXT_HI_W;

  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_LO     = 8'h21;
  localparam logic [BYTE_W-1:0] CH_HI     = 8'h7E;

  localparam logic EV_RECORD = 1'b0;
  localparam logic EV_REJECT = 1'b1;

endpackage

`default_nettype wire

[hdl/brfp_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface brfp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [brfp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hdl/brfp_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface brfp_result_if;
  logic                            valid;
  logic                            ready;
  logic                            event_res;
  logic [brfp_pkg::NTXT_W-1:0]     name_text;
  logic [brfp_pkg::NLEN_W-1:0]     name_length;
  logic [brfp_pkg::VTXT_LO_W-1:0]  value_text_low;
  logic [brfp_pkg::VTXT_HI_W-1:0]  value_text_high;
  logic [brfp_pkg::VLEN_W-1:0]     value_length;
  logic                            truncated;

  modport source (output valid, output event_res, output name_text, output name_length,
                  output value_text_low, output value_text_high, output value_length,
                  output truncated, input ready);
  modport sink   (input valid, input event_res, input name_text, input name_length,
                  input value_text_low, input value_text_high, input value_length,
                  input truncated, output ready);
endinterface

`default_nettype wire

[hdl/brace_record_field_parser.sv]
// Parses {NAME:VALUE,NAME:VALUE} frames one byte per beat. A byte is taken on every
// cycle in which the result register is empty or being drained, so the block sustains
// one byte per clock, and a result beat is registered in the cycle after its byte; the only
// thing that holds the input back is a result beat waiting for its sink. A ',' or '}' in a value
// gives a record beat (name, value, lengths, truncated flag); a ',' or '}' in a name,
// or any byte outside 0x21..0x7E, gives a reject beat with all other fields zero and
// sends the parser back to idle. Names keep up to 7 characters and values up to 11;
// extra characters are dropped and the record is flagged truncated.
`timescale 1ns / 1ps
`default_nettype none

module brace_record_field_parser (
  input  wire logic    clk,
  input  wire logic    rst,
  brfp_byte_if.sink    rx,
  brfp_result_if.source res
);
  import brfp_pkg::*;

  `include "brace_record_field_parser_assert.svh"

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NAME  = 2'd1;
  localparam logic [1:0] MODE_VALUE = 2'd2;

  logic [1:0]        mode, mode_next;
  logic [IDX_W-1:0]  char_index, char_index_next;
  logic              overflow_seen, overflow_seen_next;
  logic [NLEN_W-1:0] name_count, name_count_next;
  logic [BYTE_W-1:0] name_store  [NAME_CAP];
  logic [BYTE_W-1:0] value_store [VALUE_CAP];

  logic                 res_valid;
  logic                 event_res;
  logic [NTXT_W-1:0]    name_text;
  logic [NLEN_W-1:0]    name_length;
  logic [VTXT_W-1:0]    value_text;
  logic [VLEN_W-1:0]    value_length;
  logic                 truncated;

  logic [NTXT_W-1:0]    name_text_next;
  logic [VTXT_W-1:0]    value_text_next;

  logic [BYTE_W-1:0] c;
  logic              accept, in_name, in_value, is_print;
  logic              emit_rec, emit_rej, name_wr, value_wr;

  assign c        = rx.rx_byte;
  assign rx.ready = !res_valid || res.ready;
  assign accept   = rx.valid && rx.ready;
  assign in_name  = (mode == MODE_NAME);
  assign in_value = (mode == MODE_VALUE);
  assign is_print = (c >= CH_LO) && (c <= CH_HI);

  always_comb begin
    mode_next          = mode;
    char_index_next    = char_index;
    overflow_seen_next = overflow_seen;
    name_count_next    = name_count;
    emit_rec           = 1'b0;
    emit_rej           = 1'b0;
    name_wr            = 1'b0;
    value_wr           = 1'b0;
    priority if (c == CH_LBRACE) begin
      if (!in_name && !in_value) begin
        mode_next          = MODE_NAME;
        char_index_next    = '0;
        overflow_seen_next = 1'b0;
      end
    end else if (c == CH_COLON) begin
      if (in_name) begin
        name_count_next = char_index[NLEN_W-1:0];
        mode_next       = MODE_VALUE;
        char_index_next = '0;
      end
    end else if (c == CH_COMMA || c == CH_RBRACE) begin
      if (in_value) begin
        emit_rec           = 1'b1;
        overflow_seen_next = 1'b0;
        char_index_next    = '0;
        mode_next          = (c == CH_COMMA) ? MODE_NAME : MODE_IDLE;
      end else if (in_name) begin
        emit_rej = 1'b1;
      end
    end else if (!is_print) begin
      emit_rej = 1'b1;
    end else begin
      if (in_name) begin
        if (char_index < IDX_W'(NAME_CAP)) begin
          name_wr         = 1'b1;
          char_index_next = char_index + IDX_W'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else if (in_value) begin
        if (char_index < IDX_W'(VALUE_CAP)) begin
          value_wr        = 1'b1;
          char_index_next = char_index + IDX_W'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
    end
    if (emit_rej) begin
      mode_next          = MODE_IDLE;
      char_index_next    = '0;
      overflow_seen_next = 1'b0;
    end
  end

  always_comb begin
    name_text_next  = '0;
    value_text_next = '0;
    for (int i = 0; i < NAME_CAP; i++) begin
      if (NLEN_W'(i) < name_count) begin
        name_text_next[BYTE_W*i +: BYTE_W] = name_store[i];
      end
    end
    for (int i = 0; i < VALUE_CAP; i++) begin
      if (IDX_W'(i) < char_index) begin
        value_text_next[BYTE_W*i +: BYTE_W] = value_store[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      char_index    <= '0;
      overflow_seen <= 1'b0;
      name_count    <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      char_index    <= char_index_next;
      overflow_seen <= overflow_seen_next;
      name_count    <= name_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NAME_CAP; i++) begin
      if (accept && name_wr && char_index == IDX_W'(i)) begin
        name_store[i] <= c;
      end
    end
    for (int i = 0; i < VALUE_CAP; i++) begin
      if (accept && value_wr && char_index == IDX_W'(i)) begin
        value_store[i] <= c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= emit_rec || emit_rej;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (emit_rec || emit_rej)) begin
      event_res    <= emit_rej ? EV_REJECT : EV_RECORD;
      name_text    <= emit_rej ? '0 : name_text_next;
      name_length  <= emit_rej ? '0 : name_count;
      value_text   <= emit_rej ? '0 : value_text_next;
      value_length <= emit_rej ? '0 : VLEN_W'(char_index);
      truncated    <= emit_rej ? 1'b0 : overflow_seen;
    end
  end

  assign res.valid           = res_valid;
  assign res.event_res       = event_res;
  assign res.name_text       = name_text;
  assign res.name_length     = name_length;
  assign res.value_text_low  = value_text[VTXT_LO_W-1:0];
  assign res.value_text_high = value_text[VTXT_W-1:VTXT_LO_W];
  assign res.value_length    = value_length;
  assign res.truncated       = truncated;

  `BRFP_ASSERT_NOW(a_reject_clean, res_valid && event_res == EV_REJECT,
    name_length == '0 && value_length == '0 && !truncated, "reject beat carries data")
  `BRFP_ASSERT_NEXT(a_bad_byte_rejects, accept && !is_print,
    res_valid && event_res == EV_REJECT && mode == MODE_IDLE, "bad byte not rejected")
  `BRFP_ASSERT_NOW(a_name_bound, mode == MODE_NAME,
    char_index <= IDX_W'(NAME_CAP), "name index past capacity")
  `BRFP_ASSERT_NOW(a_stall_blocks, res_valid && !res.ready,
    !rx.ready, "byte taken while result stalled")

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import brfp_pkg::*;

  typedef enum logic [1:0] {
    PM_IDLE  = 2'd0,
    PM_NAME  = 2'd1,
    PM_VALUE = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic                 event_res;
    logic [NTXT_W-1:0]    name_text;
    logic [NLEN_W-1:0]    name_length;
    logic [VTXT_LO_W-1:0] value_text_low;
    logic [VTXT_HI_W-1:0] value_text_high;
    logic [VLEN_W-1:0]    value_length;
    logic                 truncated;
  } field_record_t;

  logic clk;
  logic rst;

  brfp_byte_if   rx_if ();
  brfp_result_if res_if ();

  brace_record_field_parser u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if)
  );

  logic [BYTE_W-1:0] pending_bytes[$];
  field_record_t     expected_records[$];

  parse_mode_t       mode_now = PM_IDLE;
  logic [IDX_W-1:0]  char_pos = '0;
  logic [BYTE_W-1:0] name_chars[NAME_CAP];
  logic [BYTE_W-1:0] value_chars[VALUE_CAP];
  logic              chars_dropped = 1'b0;
  logic [NLEN_W-1:0] name_len_held = '0;

  logic byte_taken = 1'b0;
  int   src_gap = 0;
  int   src_calm = 0;
  int   snk_stall = 0;
  int   snk_calm = 0;

  int err_count = 0;
  int n_bytes = 0;
  int n_records = 0;
  int n_truncated = 0;
  int n_rejects = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Parse one accepted byte; return 1 when it completes a record or a reject.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] c, output field_record_t r);
    logic [VTXT_W-1:0] vbits;
    logic [NTXT_W-1:0] nbits;
    r = '0;
    if (c == CH_LBRACE) begin
      if (mode_now != PM_NAME && mode_now != PM_VALUE) begin
        mode_now = PM_NAME;
        char_pos = '0;
        chars_dropped = 1'b0;
      end
      return 1'b0;
    end
    if (c == CH_COLON) begin
      if (mode_now == PM_NAME) begin
        name_len_held = char_pos[NLEN_W-1:0];
        mode_now = PM_VALUE;
        char_pos = '0;
      end
      return 1'b0;
    end
    if (c == CH_COMMA || c == CH_RBRACE) begin
      if (mode_now == PM_VALUE) begin
        nbits = '0;
        vbits = '0;
        for (int i = 0; i < NAME_CAP; i++)
          if (i < name_len_held) nbits[8*i +: 8] = name_chars[i];
        for (int i = 0; i < VALUE_CAP; i++)
          if (i < char_pos) vbits[8*i +: 8] = value_chars[i];
        r.event_res       = EV_RECORD;
        r.name_text       = nbits;
        r.name_length     = name_len_held;
        r.value_text_low  = vbits[VTXT_LO_W-1:0];
        r.value_text_high = vbits[VTXT_W-1:VTXT_LO_W];
        r.value_length    = char_pos;
        r.truncated       = chars_dropped;
        chars_dropped = 1'b0;
        char_pos = '0;
        mode_now = (c == CH_COMMA) ? PM_NAME : PM_IDLE;
        return 1'b1;
      end
      if (mode_now != PM_NAME) return 1'b0;
    end else if (c >= CH_LO && c <= CH_HI) begin
      if (mode_now == PM_NAME) begin
        if (char_pos < NAME_CAP) begin
          name_chars[char_pos[NLEN_W-1:0]] = c;
          char_pos = char_pos + 1'b1;
        end else begin
          chars_dropped = 1'b1;
        end
      end else if (mode_now == PM_VALUE) begin
        if (char_pos < VALUE_CAP) begin
          value_chars[char_pos] = c;
          char_pos = char_pos + 1'b1;
        end else begin
          chars_dropped = 1'b1;
        end
      end
      return 1'b0;
    end
    r.event_res = EV_REJECT;
    mode_now = PM_IDLE;
    char_pos = '0;
    chars_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic void check_field(string fname, logic [VTXT_W-1:0] want,
                                      logic [VTXT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      err_count++;
    end
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 3))
          0: return CH_LBRACE;
          1: return CH_RBRACE;
          2: return CH_COLON;
          default: return CH_COMMA;
        endcase
      end
      2: return 8'($urandom_range(0, 8'h20));
      default: return 8'($urandom_range(8'h7F, 8'hFF));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(0, 59) == 0) return noise_byte();
    do
      c = 8'($urandom_range(CH_LO, CH_HI));
    while (c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON || c == CH_COMMA);
    return c;
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic add_frame();
    int nfields;
    int nlen;
    int vlen;
    pending_bytes.push_back(CH_LBRACE);
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      nlen = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
      vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 10);
      for (int k = 0; k < nlen; k++) pending_bytes.push_back(text_byte());
      if ($urandom_range(0, 14) != 0) pending_bytes.push_back(CH_COLON);
      for (int k = 0; k < vlen; k++) pending_bytes.push_back(text_byte());
      pending_bytes.push_back((f == nfields - 1) ? CH_RBRACE : CH_COMMA);
    end
  endtask

  // Source: present the next byte, with random gaps between beats.
  always @(negedge clk) begin
    logic              v_n;
    logic [BYTE_W-1:0] b_n;
    v_n = rx_if.valid;
    b_n = rx_if.rx_byte;
    if (!rst && (!rx_if.valid || byte_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        v_n = 1'b0;
      end else if (pending_bytes.size() > 0) begin
        v_n = 1'b1;
        b_n = pending_bytes.pop_front();
        src_gap = pick_gap(src_calm);
      end else begin
        v_n = 1'b0;
      end
    end
    rx_if.valid   <= v_n;
    rx_if.rx_byte <= b_n;
  end

  // Sink: stall the result channel at random.
  always @(negedge clk) begin
    logic r_n;
    r_n = 1'b1;
    if (snk_stall == 0 && $urandom_range(0, 3) == 0) snk_stall = pick_gap(snk_calm);
    if (snk_stall > 0) begin
      snk_stall--;
      r_n = 1'b0;
    end
    res_if.ready <= r_n;
  end

  always @(posedge clk) begin
    field_record_t got;
    field_record_t want;
    field_record_t fresh;
    byte_taken <= rx_if.valid && rx_if.ready;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        got = {res_if.event_res, res_if.name_text, res_if.name_length, res_if.value_text_low,
               res_if.value_text_high, res_if.value_length, res_if.truncated};
        if (expected_records.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          err_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("event_res", VTXT_W'(want.event_res), VTXT_W'(got.event_res));
          check_field("name_text", VTXT_W'(want.name_text), VTXT_W'(got.name_text));
          check_field("name_length", VTXT_W'(want.name_length), VTXT_W'(got.name_length));
          check_field("value_text_low", VTXT_W'(want.value_text_low),
                      VTXT_W'(got.value_text_low));
          check_field("value_text_high", VTXT_W'(want.value_text_high),
                      VTXT_W'(got.value_text_high));
          check_field("value_length", VTXT_W'(want.value_length),
                      VTXT_W'(got.value_length));
          check_field("truncated", VTXT_W'(want.truncated), VTXT_W'(got.truncated));
          if (want.event_res == EV_REJECT) n_rejects++;
          else n_records++;
          if (want.truncated) n_truncated++;
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        n_bytes++;
        if (parse_byte(rx_if.rx_byte, fresh)) expected_records.push_back(fresh);
      end
    end
  end

  initial begin
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;

    // brace in name and value, colon in value, boundary printables, idle junk
    push_text("{!{:~:{,}},:x");
    pending_bytes.push_back(8'h00);
    push_text("{:");
    pending_bytes.push_back(8'hFF);
    push_text("{:}");
    pending_bytes.push_back(8'h20);
    push_text("{ab");
    pending_bytes.push_back(8'h7F);

    while (pending_bytes.size() < 1620) begin
      case ($urandom_range(0, 9))
        0: begin
          for (int k = $urandom_range(1, 8); k > 0; k--)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          for (int k = $urandom_range(1, 3); k > 0; k--) pending_bytes.push_back(noise_byte());
          add_frame();
        end
        default: add_frame();
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || rx_if.valid) @(posedge clk);
    while (expected_records.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bytes in, %0d records out (%0d truncated), %0d rejects",
             n_bytes, n_records, n_truncated, n_rejects);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d records outstanding", expected_records.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
